[rtl/rmcu_pkg.sv]
`default_nettype none

package rmcu_pkg;

   // Vector length and derived index widths.
   localparam int NPARS  = 8;
   localparam int IDX_W  = 3;
   localparam int ADDR_W = 2 * IDX_W;
   localparam int CNT_W  = 4;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_NPARS_IN_USE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_COUNT = 1'b1;

   localparam logic [CNT_W-1:0] NPARS_RESET = 4'd8;
   localparam logic [15:0]      NINIT_RESET = 16'd100;

   // Divider widths: magnitude plus rounding bias, and divisor up to 2^32.
   localparam int DIV_NUM_W = 65;
   localparam int DIV_DEN_W = 33;
   localparam int DIV_CNT_W = 7;

   typedef enum logic [3:0] {
      ST_CLR,
      ST_IDLE,
      ST_ROW,
      ST_E_RD,
      ST_E_MX,
      ST_E_A1,
      ST_E_A2,
      ST_E_DS,
      ST_E_DW,
      ST_E_FIN,
      ST_OUT,
      ST_M_DS,
      ST_M_DW,
      ST_M_FIN
   } ctrl_state_type;

   typedef enum logic [1:0] {
      MODE_ACC,
      MODE_BATCH,
      MODE_REC
   } walk_mode_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_CLR,
      OP_ROW,
      OP_E_RD,
      OP_E_MX,
      OP_E_A1,
      OP_E_A2,
      OP_E_DS,
      OP_E_FIN,
      OP_M_DS,
      OP_M_FIN
   } dp_op_type;

   typedef struct packed {
      dp_op_type            op;
      walk_mode_type        walk;
      logic [IDX_W-1:0]     j;
      logic [IDX_W-1:0]     k;
   } dp_cmd_type;

   typedef struct packed {
      logic                 complete;
      walk_mode_type        mode;
      logic [IDX_W-1:0]     last_idx;
      logic                 div_done;
   } dp_status_type;

   function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         sadd = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         sadd = s;
      end
   endfunction

   function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63]) begin
         ssub = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         ssub = s;
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   function automatic logic signed [63:0] sext32(input logic signed [31:0] v);
      sext32 = {{32{v[31]}}, v};
   endfunction

endpackage

`default_nettype wire

[rtl/rmcu_req_if.sv]
`default_nettype none

interface rmcu_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample_value;

   modport source (output valid, output sample_value, input ready);
   modport sink   (input valid, input sample_value, output ready);
endinterface

`default_nettype wire

[rtl/rmcu_rsp_if.sv]
`default_nettype none

interface rmcu_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         cov_row;
   logic [2:0]         cov_col;
   logic signed [63:0] cov_value;
   logic               last_entry;

   modport source (output valid, output cov_row, output cov_col, output cov_value,
                   output last_entry, input ready);
   modport sink   (input valid, input cov_row, input cov_col, input cov_value,
                   input last_entry, output ready);
endinterface

`default_nettype wire

[rtl/running_mean_covariance_update_top.sv]
`default_nettype none

// Running mean and covariance of a stream of sample vectors, Q16.16 values in and
// saturated Q32.32 covariance entries out. Each req transaction carries one vector
// element; a sample completes after npars_in_use elements (CSR index 0, 1..8). The
// first initial_count samples (CSR index 1) only accumulate sums and cross
// products; on the last of them the batch mean and covariance are formed, and every
// later sample updates them recursively. After the batch step and after each
// recursive update the n-by-n matrix leaves as n*n rsp transactions, row by row,
// with last_entry on the final one. An element that does not complete a sample
// does not take the controller out of idle. A completed sample keeps req_ready low
// while it is processed, and the walk waits at each entry while rsp_ready is low.
// The batch and recursive walks share one divider, which produces one quotient bit
// per cycle and serves each of their mean elements and matrix entries in turn.
// After reset a clearing pass over all 64 entries zeroes the matrix memories before
// the first element is accepted; configuration writes are taken at any time and
// should be made only while the block is idle.

module running_mean_covariance_update_top
   import rmcu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   rmcu_req_if.sink                    req,
   rmcu_rsp_if.source                  rsp,
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;
   logic          req_fire;

   // A transaction is taken only while the controller sits idle.
   assign req_fire  = req.valid && req_ready;
   assign req.ready = req_ready;

   rmcu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rmcu_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_fire         (req_fire),
      .req_sample_value (req.sample_value),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .out_row          (rsp.cov_row),
      .out_col          (rsp.cov_col),
      .out_value        (rsp.cov_value),
      .out_last         (rsp.last_entry)
   );

endmodule

`default_nettype wire

[rtl/rmcu_div.sv]
`default_nettype none

// Rounded signed-by-unsigned divide, one quotient bit per cycle.
module rmcu_div
   import rmcu_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic signed [63:0]    dividend,
   input  wire logic [DIV_DEN_W-1:0]  divisor,
   output logic                       done,
   output logic signed [63:0]         quotient
);

   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic                 neg_ff;

   logic [DIV_DEN_W-1:0] den_use;
   logic [63:0]          mag;
   logic [DIV_DEN_W:0]   trial;
   logic                 ge;
   logic [63:0]          q64;

   always_comb begin
      den_use = (divisor == '0) ? DIV_DEN_W'(1) : divisor;
      mag     = dividend[63] ? (64'd0 - 64'(dividend)) : 64'(dividend);
      trial   = {rem_ff, num_ff[DIV_NUM_W-1]};
      ge      = trial >= {1'b0, den_ff};
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = {1'b0, mag} + DIV_NUM_W'(den_use >> 1);
         rem_in = '0;
         cnt_in = DIV_CNT_W'(DIV_NUM_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
         num_in = {num_ff[DIV_NUM_W-2:0], ge};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= den_use;
         neg_ff <= dividend[63];
      end
   end

   assign q64      = num_ff[63:0];
   assign quotient = neg_ff ? $signed(64'd0 - q64) : $signed(q64);
   assign done     = done_ff;

endmodule

`default_nettype wire

[rtl/rmcu_datapath.sv]
`default_nettype none

module rmcu_datapath
   import rmcu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dp_cmd_type             cmd,
   output dp_status_type               status,
   input  wire logic                   req_fire,
   input  wire logic signed [31:0]     req_sample_value,
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic [2:0]                  out_row,
   output logic [2:0]                  out_col,
   output logic signed [63:0]          out_value,
   output logic                        out_last
);

   logic [CNT_W-1:0]   npars_ff;
   logic [15:0]        ninit_ff;
   logic [CNT_W-1:0]   elem_idx_ff;
   logic [31:0]        smp_cnt_ff;
   logic [31:0]        i_ff;

   logic signed [31:0] smp_buf_ff [NPARS];
   logic signed [31:0] mean_ff    [NPARS];
   logic signed [63:0] sum_ff     [NPARS];

   logic signed [31:0] xj_ff, mj_ff;
   logic signed [63:0] mm_ff, xx_ff, acc_ff, aux_ff;

   logic signed [63:0] cov_mem [2**ADDR_W];
   logic signed [63:0] mo_mem  [2**ADDR_W];
   logic signed [63:0] cov_rd_ff, mo_rd_ff;

   logic [CNT_W-1:0]   n_eff;
   logic [15:0]        ninit_eff;
   logic [CNT_W-1:0]   elem_next;
   logic [32:0]        ip1;
   logic [IDX_W-1:0]   rd_idx;
   logic signed [31:0] rd_x, rd_m;
   logic signed [63:0] rd_s;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   logic [ADDR_W-1:0]  addr;
   logic               mem_we, mem_re;
   logic signed [63:0] mem_wdata, mo_wdata;
   logic               div_start;
   logic signed [63:0] div_dividend;
   logic [DIV_DEN_W-1:0] div_divisor;
   logic               div_done;
   logic signed [63:0] div_q;
   logic signed [63:0] fin_value;

   // Effective register values.
   always_comb begin
      if (npars_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (npars_ff > CNT_W'(NPARS)) begin
         n_eff = CNT_W'(NPARS);
      end else begin
         n_eff = npars_ff;
      end
      ninit_eff = (ninit_ff < 16'd2) ? 16'd2 : ninit_ff;
   end

   assign elem_next = elem_idx_ff + CNT_W'(1);
   assign ip1       = {1'b0, smp_cnt_ff} + 33'd1;

   always_comb begin
      status.complete = req_fire && !(elem_next < n_eff);
      if (ip1 < {17'd0, ninit_eff}) begin
         status.mode = MODE_ACC;
      end else if (ip1 == {17'd0, ninit_eff}) begin
         status.mode = MODE_BATCH;
      end else begin
         status.mode = MODE_REC;
      end
      status.last_idx = IDX_W'(n_eff - CNT_W'(1));
      status.div_done = div_done;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         npars_ff <= NPARS_RESET;
         ninit_ff <= NINIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NPARS_IN_USE:  npars_ff <= csr_wdata[CNT_W-1:0];
            CSR_INITIAL_COUNT: ninit_ff <= csr_wdata[15:0];
            default:           ;
         endcase
      end
   end

   // Element and sample counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         elem_idx_ff <= '0;
         smp_cnt_ff  <= '0;
      end else if (req_fire) begin
         if (status.complete) begin
            elem_idx_ff <= '0;
            if (smp_cnt_ff != 32'hFFFF_FFFF) begin
               smp_cnt_ff <= smp_cnt_ff + 32'd1;
            end
         end else begin
            elem_idx_ff <= elem_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         smp_buf_ff[elem_idx_ff[IDX_W-1:0]] <= req_sample_value;
         if (status.complete) begin
            i_ff <= smp_cnt_ff;
         end
      end
   end

   // One shared read index for the small vectors.
   assign rd_idx = (cmd.op == OP_E_RD || cmd.op == OP_E_MX) ? cmd.k : cmd.j;
   assign rd_x   = smp_buf_ff[rd_idx];
   assign rd_m   = mean_ff[rd_idx];
   assign rd_s   = sum_ff[rd_idx];

   // Shared multiplier: mean product first, then sample product.
   assign mul_a = (cmd.op == OP_E_RD) ? mj_ff : xj_ff;
   assign mul_b = (cmd.op == OP_E_RD) ? rd_m  : rd_x;
   assign mul_p = mul_a * mul_b;

   // Divider operands.
   always_comb begin
      div_start    = (cmd.op == OP_M_DS) || (cmd.op == OP_E_DS);
      div_dividend = acc_ff;
      div_divisor  = {1'b0, i_ff};
      if (cmd.op == OP_M_DS) begin
         if (cmd.walk == MODE_BATCH) begin
            div_dividend = rd_s;
            div_divisor  = DIV_DEN_W'(ninit_eff);
         end else begin
            div_dividend = sext32(rd_x) - sext32(rd_m);
            div_divisor  = ip1 - 33'd1 + 33'd1 == 33'd0 ? 33'd1 : {1'b0, i_ff} + 33'd1;
         end
      end else if (cmd.walk == MODE_BATCH) begin
         div_divisor = DIV_DEN_W'(ninit_eff - 16'd1);
      end
   end

   rmcu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // Mean vector and element sums.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < NPARS; e++) begin
            mean_ff[e] <= '0;
            sum_ff[e]  <= '0;
         end
      end else begin
         if (cmd.op == OP_ROW && cmd.walk == MODE_ACC) begin
            sum_ff[cmd.j] <= sadd(rd_s, sext32(rd_x));
         end
         if (cmd.op == OP_M_FIN) begin
            if (cmd.walk == MODE_BATCH) begin
               mean_ff[cmd.j] <= sat32(div_q);
            end else begin
               mean_ff[cmd.j] <= sat32(sext32(rd_m) + div_q);
            end
         end
      end
   end

   // Final value of one matrix entry.
   always_comb begin
      unique case (cmd.walk)
         MODE_ACC:   fin_value = acc_ff;
         MODE_BATCH: fin_value = ssub(div_q, mm_ff);
         MODE_REC:   fin_value = sadd(aux_ff, div_q);
         default:    fin_value = acc_ff;
      endcase
   end

   // Entry working registers.
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_ROW: begin
            xj_ff <= rd_x;
            mj_ff <= rd_m;
         end
         OP_E_RD: mm_ff <= mul_p;
         OP_E_MX: xx_ff <= mul_p;
         OP_E_A1: begin
            unique case (cmd.walk)
               MODE_ACC:   acc_ff <= sadd(cov_rd_ff, xx_ff);
               MODE_BATCH: acc_ff <= ssub(cov_rd_ff, mm_ff);
               default:    acc_ff <= ssub(xx_ff, cov_rd_ff);
            endcase
            aux_ff <= ssub(mo_rd_ff, mm_ff);
         end
         OP_E_A2: begin
            acc_ff <= ssub(acc_ff, mm_ff);
            aux_ff <= sadd(cov_rd_ff, aux_ff);
         end
         OP_E_FIN: begin
            out_row   <= cmd.j;
            out_col   <= cmd.k;
            out_value <= fin_value;
            out_last  <= (cmd.j == status.last_idx) && (cmd.k == status.last_idx);
         end
         default: ;
      endcase
   end

   // Matrix memories: covariance and previous mean outer product.
   assign addr      = {cmd.j, cmd.k};
   assign mem_re    = (cmd.op == OP_E_RD);
   assign mem_we    = (cmd.op == OP_CLR) || (cmd.op == OP_E_FIN);
   assign mem_wdata = (cmd.op == OP_CLR) ? 64'sd0 : fin_value;
   assign mo_wdata  = (cmd.op == OP_CLR || cmd.walk == MODE_ACC) ? 64'sd0 : mm_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cov_mem[addr] <= mem_wdata;
      end
      if (mem_re) begin
         cov_rd_ff <= cov_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we && (cmd.op == OP_CLR || cmd.walk != MODE_ACC)) begin
         mo_mem[addr] <= mo_wdata;
      end
      if (mem_re) begin
         mo_rd_ff <= mo_mem[addr];
      end
   end

endmodule

`default_nettype wire

[rtl/rmcu_ctrl.sv]
`default_nettype none

module rmcu_ctrl
   import rmcu_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   ctrl_state_type   state_ff, state_in;
   walk_mode_type    walk_ff, walk_in;
   walk_mode_type    mode_ff, mode_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic             row_end, col_end;
   logic             clr_end;

   assign row_end = (j_ff == status.last_idx);
   assign col_end = (k_ff == status.last_idx);
   assign clr_end = (j_ff == IDX_W'(NPARS - 1)) && (k_ff == IDX_W'(NPARS - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      walk_in  = walk_ff;
      mode_in  = mode_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_CLR: begin
            if (clr_end) begin
               state_in = ST_IDLE;
               j_in     = '0;
               k_in     = '0;
            end else if (k_ff == IDX_W'(NPARS - 1)) begin
               j_in = j_ff + IDX_W'(1);
               k_in = '0;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid && status.complete) begin
               mode_in = status.mode;
               j_in    = '0;
               k_in    = '0;
               if (status.mode == MODE_REC) begin
                  walk_in  = MODE_REC;
                  state_in = ST_M_DS;
               end else begin
                  walk_in  = MODE_ACC;
                  state_in = ST_ROW;
               end
            end
         end
         ST_ROW:  state_in = ST_E_RD;
         ST_E_RD: state_in = ST_E_MX;
         ST_E_MX: state_in = ST_E_A1;
         ST_E_A1: begin
            unique case (walk_ff)
               MODE_ACC:   state_in = ST_E_FIN;
               MODE_BATCH: state_in = ST_E_DS;
               default:    state_in = ST_E_A2;
            endcase
         end
         ST_E_A2: state_in = ST_E_DS;
         ST_E_DS: state_in = ST_E_DW;
         ST_E_DW: begin
            if (status.div_done) begin
               state_in = ST_E_FIN;
            end
         end
         ST_E_FIN, ST_OUT: begin
            if (state_ff == ST_E_FIN && walk_ff != MODE_ACC) begin
               state_in = ST_OUT;
            end else if (state_ff == ST_OUT && !rsp_ready) begin
               state_in = ST_OUT;
            end else if (!col_end) begin
               k_in     = k_ff + IDX_W'(1);
               state_in = ST_E_RD;
            end else if (!row_end) begin
               j_in     = j_ff + IDX_W'(1);
               k_in     = '0;
               state_in = ST_ROW;
            end else if (walk_ff == MODE_ACC && mode_ff == MODE_BATCH) begin
               walk_in  = MODE_BATCH;
               j_in     = '0;
               k_in     = '0;
               state_in = ST_M_DS;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_M_DS: state_in = ST_M_DW;
         ST_M_DW: begin
            if (status.div_done) begin
               state_in = ST_M_FIN;
            end
         end
         ST_M_FIN: begin
            if (row_end) begin
               j_in     = '0;
               k_in     = '0;
               state_in = ST_ROW;
            end else begin
               j_in     = j_ff + IDX_W'(1);
               state_in = ST_M_DS;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd.walk  = walk_ff;
      cmd.j     = j_ff;
      cmd.k     = k_ff;
      unique case (state_ff)
         ST_CLR:   cmd.op = OP_CLR;
         ST_IDLE: begin
            cmd.op    = OP_NOP;
            req_ready = 1'b1;
         end
         ST_ROW:   cmd.op = OP_ROW;
         ST_E_RD:  cmd.op = OP_E_RD;
         ST_E_MX:  cmd.op = OP_E_MX;
         ST_E_A1:  cmd.op = OP_E_A1;
         ST_E_A2:  cmd.op = OP_E_A2;
         ST_E_DS:  cmd.op = OP_E_DS;
         ST_E_FIN: cmd.op = OP_E_FIN;
         ST_OUT: begin
            cmd.op    = OP_NOP;
            rsp_valid = 1'b1;
         end
         ST_M_DS:  cmd.op = OP_M_DS;
         ST_M_FIN: cmd.op = OP_M_FIN;
         default:  cmd.op = OP_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         walk_ff  <= MODE_ACC;
         mode_ff  <= MODE_ACC;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         walk_ff  <= walk_in;
         mode_ff  <= mode_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

endmodule

`default_nettype wire

[tb/running_mean_covariance_update_top_tb.sv]
`default_nettype none

module running_mean_covariance_update_top_tb;
   import rmcu_pkg::*;

   // The receiver may hold off a recursive update with all eight parameters, so the
   // limit is kept far above the time such an update takes.
   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int SETTLE_CYCLES = 1000;
   localparam int RANDOM_ITEMS  = 390;

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] wdata;
      logic [31:0]           value;
      bit                    has_typed;
      logic [63:0]           typed_value;
   } stim_row_type;

   typedef struct {
      logic [2:0]  row;
      logic [2:0]  col;
      logic [63:0] value;
      logic        last;
   } cov_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rmcu_req_if req_ch();
   rmcu_rsp_if rsp_ch();

   running_mean_covariance_update_top dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Our own copy of the block's state and configuration.
   logic [3:0]         cfg_npars;
   logic [15:0]        cfg_ninit;
   logic signed [31:0] elem_buf [NPARS];
   logic [3:0]         elem_idx;
   logic [31:0]        samples_seen;
   logic signed [31:0] mean_vec [NPARS];
   logic signed [63:0] sum_vec  [NPARS];
   logic signed [63:0] outer_mm [NPARS][NPARS];
   logic signed [63:0] cov_mat  [NPARS][NPARS];

   cov_entry_type pending_entries[$];

   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   function automatic logic signed [63:0] add_clamped(logic signed [63:0] a,
                                                      logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sub_clamped(logic signed [63:0] a,
                                                      logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return s[63:0];
   endfunction

   function automatic logic signed [31:0] clamp_to_q16(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // Division rounded to nearest with ties away from zero.
   function automatic logic signed [63:0] div_nearest(logic signed [63:0] v,
                                                      logic [63:0] d);
      logic        neg;
      logic [63:0] mag;
      logic [63:0] q;
      neg = v[63];
      mag = neg ? (64'd0 - v) : v;
      if (d == 64'd0) d = 64'd1;
      q = (mag + (d >> 1)) / d;
      return neg ? (64'd0 - q) : q;
   endfunction

   function automatic logic signed [63:0] product(logic signed [31:0] a,
                                                  logic signed [31:0] b);
      logic signed [63:0] wa;
      logic signed [63:0] wb;
      wa = a;
      wb = b;
      return wa * wb;
   endfunction

   task automatic clear_statistics();
      cfg_npars = NPARS_RESET;
      cfg_ninit = NINIT_RESET;
      elem_idx = '0;
      samples_seen = '0;
      for (int j = 0; j < NPARS; j++) begin
         elem_buf[j] = '0;
         mean_vec[j] = '0;
         sum_vec[j] = '0;
         for (int k = 0; k < NPARS; k++) begin
            outer_mm[j][k] = '0;
            cov_mat[j][k] = '0;
         end
      end
   endtask

   // Takes one accepted element and queues the matrix entries it brings about.
   task automatic absorb_element(logic signed [31:0] x);
      int          n;
      logic [63:0] ninit;
      logic [63:0] i;
      logic signed [63:0] mm, t;
      cov_entry_type e;
      n = (cfg_npars == 0) ? 1 : (cfg_npars > NPARS ? NPARS : int'(cfg_npars));
      ninit = (cfg_ninit < 2) ? 64'd2 : 64'(cfg_ninit);
      i = 64'(samples_seen);
      elem_buf[elem_idx[2:0]] = x;
      elem_idx = elem_idx + 4'd1;
      if (elem_idx < n) return;
      elem_idx = '0;
      if (samples_seen != 32'hFFFF_FFFF) samples_seen = samples_seen + 1;
      if (i + 1 <= ninit) begin
         for (int j = 0; j < n; j++) begin
            sum_vec[j] = add_clamped(sum_vec[j], 64'(elem_buf[j]));
            for (int k = 0; k < n; k++) begin
               cov_mat[j][k] = add_clamped(cov_mat[j][k], product(elem_buf[j], elem_buf[k]));
            end
         end
         if (i + 1 < ninit) return;
         for (int j = 0; j < n; j++) begin
            mean_vec[j] = clamp_to_q16(div_nearest(sum_vec[j], ninit));
         end
         for (int j = 0; j < n; j++) begin
            for (int k = 0; k < n; k++) begin
               mm = product(mean_vec[j], mean_vec[k]);
               outer_mm[j][k] = mm;
               cov_mat[j][k] = sub_clamped(div_nearest(sub_clamped(cov_mat[j][k], mm),
                                                       ninit - 1), mm);
            end
         end
      end else begin
         for (int j = 0; j < n; j++) begin
            t = div_nearest(64'(elem_buf[j]) - 64'(mean_vec[j]), i + 1);
            mean_vec[j] = clamp_to_q16(64'(mean_vec[j]) + t);
         end
         for (int j = 0; j < n; j++) begin
            for (int k = 0; k < n; k++) begin
               mm = product(mean_vec[j], mean_vec[k]);
               t = div_nearest(sub_clamped(sub_clamped(product(elem_buf[j], elem_buf[k]),
                                                       cov_mat[j][k]), mm), i);
               cov_mat[j][k] = add_clamped(add_clamped(cov_mat[j][k],
                                                       sub_clamped(outer_mm[j][k], mm)), t);
               outer_mm[j][k] = mm;
            end
         end
      end
      for (int j = 0; j < n; j++) begin
         for (int k = 0; k < n; k++) begin
            e.row = j[2:0];
            e.col = k[2:0];
            e.value = cov_mat[j][k];
            e.last = (j == n - 1) && (k == n - 1);
            pending_entries.push_back(e);
         end
      end
   endtask

   // The sender: one element per transaction, with random gaps in the idling phases.
   // Valid is only lowered when a gap actually follows, so it never toggles twice
   // within one time step.
   task automatic send_element(logic [31:0] v);
      req_ch.valid <= 1'b1;
      req_ch.sample_value <= v;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      absorb_element(v);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
   endtask

   // Registers are only written once the block has gone quiet: every expected
   // entry has arrived, and an accumulation sample (which produces nothing) has had
   // time to finish.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_entries.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      settle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_NPARS_IN_USE) begin
         cfg_npars = data[3:0];
      end else begin
         cfg_ninit = data;
      end
   endtask

   // Mostly full-range words, with the extremes and small Q16.16 values mixed in.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
         default: return $urandom;
      endcase
   endfunction

   // The receiver checks every accepted transaction against the oldest expected entry
   // and draws its ready for the next cycle.
   always @(posedge clock) begin
      cov_entry_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_entries.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) begin
               $display("unexpected entry row %0d col %0d value %h", rsp_ch.cov_row,
                        rsp_ch.cov_col, rsp_ch.cov_value);
            end
         end else begin
            want = pending_entries.pop_front();
            if (rsp_ch.cov_row !== want.row || rsp_ch.cov_col !== want.col ||
                rsp_ch.cov_value !== want.value || rsp_ch.last_entry !== want.last) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10) begin
                  $display("entry mismatch: expected row %0d col %0d value %h last %b,",
                           want.row, want.col, want.value, want.last);
                  $display("   got row %0d col %0d value %h last %b", rsp_ch.cov_row,
                           rsp_ch.cov_col, rsp_ch.cov_value, rsp_ch.last_entry);
               end
            end
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("running_mean_covariance_update_top_tb: errors");
         $finish;
      end
   end

   // Directed rows. The first batch uses one parameter and two samples of the
   // largest positive value, so the batch covariance must be exactly zero. The rest
   // covers the most negative value, zero, minus one in the last place, an element
   // count of zero (taken as one), a count of fifteen (taken as eight, with all
   // 64 entries out), and initial counts of zero and one (taken as two).
   stim_row_type directed_rows[] = '{
      '{ROW_CSR,  CSR_NPARS_IN_USE,  16'd1,  32'h0, 1'b0, 64'h0},
      '{ROW_CSR,  CSR_INITIAL_COUNT, 16'd2,  32'h0, 1'b0, 64'h0},
      '{ROW_ITEM, CSR_NPARS_IN_USE,  16'd0,  32'h7FFF_FFFF, 1'b0, 64'h0},
      '{ROW_ITEM, CSR_NPARS_IN_USE,  16'd0,  32'h7FFF_FFFF, 1'b1, 64'h0},
      '{ROW_ITEM, CSR_NPARS_IN_USE,  16'd0,  32'h8000_0000, 1'b0, 64'h0},
      '{ROW_ITEM, CSR_NPARS_IN_USE,  16'd0,  32'h0000_0000, 1'b0, 64'h0},
      '{ROW_ITEM, CSR_NPARS_IN_USE,  16'd0,  32'hFFFF_FFFF, 1'b0, 64'h0},
      '{ROW_CSR,  CSR_NPARS_IN_USE,  16'd0,  32'h0, 1'b0, 64'h0},
      '{ROW_ITEM, CSR_NPARS_IN_USE,  16'd0,  32'h1234_5678, 1'b0, 64'h0},
      '{ROW_CSR,  CSR_NPARS_IN_USE,  16'd15, 32'h0, 1'b0, 64'h0},
      '{ROW_ITEM, CSR_NPARS_IN_USE,  16'd0,  32'h7FFF_FFFF, 1'b0, 64'h0},
      '{ROW_ITEM, CSR_NPARS_IN_USE,  16'd0,  32'h8000_0000, 1'b0, 64'h0},
      '{ROW_ITEM, CSR_NPARS_IN_USE,  16'd0,  32'h0000_0000, 1'b0, 64'h0},
      '{ROW_ITEM, CSR_NPARS_IN_USE,  16'd0,  32'h0000_0001, 1'b0, 64'h0},
      '{ROW_ITEM, CSR_NPARS_IN_USE,  16'd0,  32'hFFFF_FFFF, 1'b0, 64'h0},
      '{ROW_ITEM, CSR_NPARS_IN_USE,  16'd0,  32'h0001_0000, 1'b0, 64'h0},
      '{ROW_ITEM, CSR_NPARS_IN_USE,  16'd0,  32'hFFFF_0000, 1'b0, 64'h0},
      '{ROW_ITEM, CSR_NPARS_IN_USE,  16'd0,  32'h5555_5555, 1'b0, 64'h0},
      '{ROW_CSR,  CSR_NPARS_IN_USE,  16'd2,  32'h0, 1'b0, 64'h0},
      '{ROW_CSR,  CSR_INITIAL_COUNT, 16'd0,  32'h0, 1'b0, 64'h0},
      '{ROW_ITEM, CSR_NPARS_IN_USE,  16'd0,  32'hAAAA_AAAA, 1'b0, 64'h0},
      '{ROW_ITEM, CSR_NPARS_IN_USE,  16'd0,  32'h7FFF_FFFF, 1'b0, 64'h0},
      '{ROW_CSR,  CSR_INITIAL_COUNT, 16'd1,  32'h0, 1'b0, 64'h0}
   };

   initial begin
      int unsigned sent;
      int unsigned phase;
      int unsigned n;
      int unsigned wait_cycles;
      req_ch.valid = 1'b0;
      req_ch.sample_value = '0;
      clear_statistics();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with no idling on either side.
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            write_register(directed_rows[r].index, directed_rows[r].wdata);
         end else begin
            send_element(directed_rows[r].value);
            // A typed row ends a one-parameter sample; its single entry is known.
            if (directed_rows[r].has_typed && pending_entries.size() != 0) begin
               pending_entries[pending_entries.size() - 1].value =
                  directed_rows[r].typed_value;
            end
         end
      end

      // The largest initial count: the running statistics fall back into
      // accumulation for a few samples, which produce nothing.
      write_register(CSR_NPARS_IN_USE, 16'd2);
      write_register(CSR_INITIAL_COUNT, 16'hFFFF);
      repeat (8) send_element(pick_value());
      write_register(CSR_INITIAL_COUNT, 16'd3);

      // Random part: phases of whole samples, each with its own element count and
      // its own idling pattern. Element counts only change at sample boundaries.
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(9))
            0: n = 8;
            1: n = $urandom_range(9, 15);
            2: n = 0;
            default: n = $urandom_range(1, 4);
         endcase
         write_register(CSR_NPARS_IN_USE, 16'(n));
         if ($urandom_range(3) == 0) begin
            write_register(CSR_INITIAL_COUNT, 16'($urandom_range(0, 6)));
         end
         if (n == 0) n = 1;
         if (n > NPARS) n = NPARS;
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 88; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 88; end
            default: begin sender_idle_pct = 29; receiver_stall_pct = 29; end
         endcase
         repeat ((n == NPARS) ? 2 : $urandom_range(3, 8)) begin
            repeat (n) begin
               send_element(pick_value());
               sent++;
            end
         end
         phase++;
      end

      req_ch.valid <= 1'b0;
      while (pending_entries.size() != 0) @(posedge clock);
      wait_cycles = 0;
      while (wait_cycles < SETTLE_CYCLES) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (mismatch_count == 0) begin
         $display("running_mean_covariance_update_top_tb: clean");
      end else begin
         $display("running_mean_covariance_update_top_tb: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

[running_mean_covariance_update_top.f]
rtl/rmcu_pkg.sv
rtl/rmcu_req_if.sv
rtl/rmcu_rsp_if.sv
rtl/rmcu_div.sv
rtl/rmcu_datapath.sv
rtl/rmcu_ctrl.sv
rtl/running_mean_covariance_update_top.sv
tb/running_mean_covariance_update_top_tb.sv
